// ===== hw/rtl/abt_pkg.sv =====
// shared types and constants for the agglomerative box tree builder
package abt_pkg;

  localparam int COORD_BITS    = 20;
  localparam int MAX_INST_DFLT = 64;
  localparam int NODE_W        = 7;
  localparam int NODE_DEPTH    = 128;
  localparam int INST_W        = 6;
  localparam int AREA_W        = 2 * COORD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [NODE_W-1:0] node_idx_t;

  // one stored box, as kept in the corner memory
  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // input item
  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    logic   last_box;
  } box_in_t;

  // result item
  typedef struct packed {
    node_idx_t         node_index;
    node_idx_t         left_child;
    node_idx_t         right_child;
    coord_t            out_min_x;
    coord_t            out_min_y;
    coord_t            out_min_z;
    coord_t            out_max_x;
    coord_t            out_max_y;
    coord_t            out_max_z;
    logic [INST_W-1:0] leaf_instance;
    logic              last_node;
  } node_out_t;

endpackage

// ===== hw/rtl/abt_ram.sv =====
// generic simple dual port ram, one write and one registered read port
module abt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/agglomerative_box_tree_build.sv =====
// top level: box loader and tree build sequencer around one shared multiplier
//
// Usage: present a box on box with start high; it is taken on a clock edge
// where start is high and busy is low. Boxes load one per cycle and become
// leaves 1..N in arrival order; boxes past MAX_INSTANCES are dropped. The box
// with last_box set starts the build and busy rises until the root is out.
// The build pairs mutual nearest neighbours by half surface area of the union
// box. Each new internal node appears on node for one cycle with strobe high;
// a root record with node_index 0 and last_node high closes the build.
// The receiver cannot stall: every strobe cycle carries a new item.
// A partner search over n active nodes tries each other node as a candidate,
// paced by the single cost multiplier used three times per candidate and by
// the registered reads of the slot and corner memories.
// Reset (synchronous, rst high) empties the leaf list and returns to idle;
// memory contents are left as they are and are rewritten before use.
module agglomerative_box_tree_build #(
  parameter int MAX_INSTANCES = abt_pkg::MAX_INST_DFLT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  abt_pkg::box_in_t   box,
  output logic               strobe,
  output abt_pkg::node_out_t node
);

  import abt_pkg::*;

  localparam int SLOT_W = $clog2(MAX_INSTANCES);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int NA_W   = $clog2(NODE_DEPTH);
  localparam int PROD_W = 2 * COORD_BITS;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_BST  = 5'd1;
  localparam logic [4:0] S_PA0  = 5'd2;
  localparam logic [4:0] S_PA1  = 5'd3;
  localparam logic [4:0] S_PA2  = 5'd4;
  localparam logic [4:0] S_J0   = 5'd5;
  localparam logic [4:0] S_J1   = 5'd6;
  localparam logic [4:0] S_J2   = 5'd7;
  localparam logic [4:0] S_M0   = 5'd8;
  localparam logic [4:0] S_M1   = 5'd9;
  localparam logic [4:0] S_M2   = 5'd10;
  localparam logic [4:0] S_CMP  = 5'd11;
  localparam logic [4:0] S_RB   = 5'd12;
  localparam logic [4:0] S_RC   = 5'd13;
  localparam logic [4:0] S_MG0  = 5'd14;
  localparam logic [4:0] S_MG1  = 5'd15;
  localparam logic [4:0] S_MG2  = 5'd16;
  localparam logic [4:0] S_MG3  = 5'd17;
  localparam logic [4:0] S_MG4  = 5'd18;
  localparam logic [4:0] S_RT0  = 5'd19;
  localparam logic [4:0] S_RT1  = 5'd20;
  localparam logic [4:0] S_RT2  = 5'd21;

  logic [4:0]        state;
  logic [4:0]        ret;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  j;
  logic [SLOT_W-1:0] a;
  logic [SLOT_W-1:0] b;
  logic [SLOT_W-1:0] srch;
  logic [SLOT_W-1:0] best_j;
  logic [AREA_W-1:0] best_area;
  logic [AREA_W-1:0] acc;
  node_idx_t         nn;
  node_idx_t         ia;
  node_idx_t         ib;
  node_idx_t         tail;
  node_idx_t         root;
  logic              merged;
  box_t              pa_box;
  box_t              a_box;
  logic [COORD_BITS-1:0] e0, e1, e2;

  logic              accept;
  logic [SLOT_W-1:0] n_last;

  // memory ports
  logic              act_we;
  logic [SLOT_W-1:0] act_waddr;
  node_idx_t         act_wdata;
  logic [SLOT_W-1:0] act_raddr;
  node_idx_t         act_rdata;
  logic              cor_we;
  logic [NA_W-1:0]   cor_waddr;
  box_t              cor_wdata;
  logic [NA_W-1:0]   cor_raddr;
  box_t              cor_rdata;

  box_t              in_box;
  box_t              un_box;
  logic [COORD_BITS-1:0] mul_x, mul_y;
  logic [PROD_W-1:0] prod;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign n_last = SLOT_W'(n - CNT_W'(1));

  assign in_box = '{min_x: box.min_x, min_y: box.min_y, min_z: box.min_z,
                    max_x: box.max_x, max_y: box.max_y, max_z: box.max_z};

  // union extent on one axis, negative counts as zero
  function automatic logic [COORD_BITS-1:0] extent(coord_t pmin, coord_t pmax,
                                                   coord_t qmin, coord_t qmax);
    coord_t                    hi;
    coord_t                    lo;
    logic signed [COORD_BITS:0] d;
    begin
      hi = (pmax > qmax) ? pmax : qmax;
      lo = (pmin < qmin) ? pmin : qmin;
      d  = {hi[COORD_BITS-1], hi} - {lo[COORD_BITS-1], lo};
      extent = d[COORD_BITS] ? '0 : d[COORD_BITS-1:0];
    end
  endfunction

  // union box of the held box and the box just read
  always_comb begin
    un_box.min_x = (a_box.min_x < cor_rdata.min_x) ? a_box.min_x : cor_rdata.min_x;
    un_box.min_y = (a_box.min_y < cor_rdata.min_y) ? a_box.min_y : cor_rdata.min_y;
    un_box.min_z = (a_box.min_z < cor_rdata.min_z) ? a_box.min_z : cor_rdata.min_z;
    un_box.max_x = (a_box.max_x > cor_rdata.max_x) ? a_box.max_x : cor_rdata.max_x;
    un_box.max_y = (a_box.max_y > cor_rdata.max_y) ? a_box.max_y : cor_rdata.max_y;
    un_box.max_z = (a_box.max_z > cor_rdata.max_z) ? a_box.max_z : cor_rdata.max_z;
  end

  // shared multiplier, one extent product per cycle
  always_comb begin
    case (state)
      S_M0: begin
        mul_x = e0;
        mul_y = e1;
      end
      S_M1: begin
        mul_x = e1;
        mul_y = e2;
      end
      default: begin
        mul_x = e2;
        mul_y = e0;
      end
    endcase
  end
  assign prod = mul_x * mul_y;

  // read addresses
  always_comb begin
    case (state)
      S_PA0:   act_raddr = srch;
      S_J0:    act_raddr = j[SLOT_W-1:0];
      S_MG0:   act_raddr = a;
      S_MG1:   act_raddr = b;
      S_MG2:   act_raddr = n_last;
      default: act_raddr = '0;
    endcase
    cor_raddr = act_rdata;
  end

  // write ports
  always_comb begin
    act_we    = 1'b0;
    act_waddr = count[SLOT_W-1:0];
    act_wdata = NODE_W'(count) + NODE_W'(1);
    cor_we    = 1'b0;
    cor_waddr = NODE_W'(count) + NODE_W'(1);
    cor_wdata = in_box;
    case (state)
      S_IDLE: begin
        if (accept && (count < CNT_W'(MAX_INSTANCES))) begin
          act_we = 1'b1;
          cor_we = 1'b1;
        end
      end
      S_MG3: begin
        act_we    = 1'b1;
        act_waddr = a;
        act_wdata = nn;
        cor_we    = 1'b1;
        cor_waddr = nn;
        cor_wdata = un_box;
      end
      S_MG4: begin
        act_we    = 1'b1;
        act_waddr = b;
        act_wdata = tail;
      end
      default: begin
        act_we = 1'b0;
      end
    endcase
  end

  abt_ram #(.WIDTH(NODE_W), .DEPTH(MAX_INSTANCES)) u_slot_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  abt_ram #(.WIDTH($bits(box_t)), .DEPTH(NODE_DEPTH)) u_corner_ram (
    .clk   (clk),
    .we    (cor_we),
    .waddr (cor_waddr),
    .wdata (cor_wdata),
    .raddr (cor_raddr),
    .rdata (cor_rdata)
  );

  // build sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      merged <= 1'b0;
      ret    <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      // a result goes out after each merge and after the root
      strobe <= (state == S_MG3) || (state == S_RT2);
      case (state)
        // load boxes
        S_IDLE: begin
          if (accept) begin
            if (count < CNT_W'(MAX_INSTANCES)) begin
              count <= count + CNT_W'(1);
            end
            if (box.last_box) begin
              state <= S_BST;
            end
          end
        end
        S_BST: begin
          n      <= count;
          nn     <= NODE_W'(count) + NODE_W'(1);
          a      <= '0;
          merged <= 1'b0;
          srch   <= '0;
          ret    <= S_RB;
          state  <= (count > CNT_W'(1)) ? S_PA0 : S_RT0;
        end
        // partner search: fetch the probe box
        S_PA0: state <= S_PA1;
        S_PA1: state <= S_PA2;
        S_PA2: begin
          pa_box    <= cor_rdata;
          j         <= '0;
          best_j    <= '0;
          best_area <= '1;
          state     <= S_J0;
        end
        // walk the candidates
        S_J0: begin
          if (j == n) begin
            state <= ret;
          end else if (j[SLOT_W-1:0] == srch) begin
            j <= j + CNT_W'(1);
          end else begin
            state <= S_J1;
          end
        end
        S_J1: state <= S_J2;
        S_J2: begin
          e0    <= extent(pa_box.min_x, pa_box.max_x, cor_rdata.min_x, cor_rdata.max_x);
          e1    <= extent(pa_box.min_y, pa_box.max_y, cor_rdata.min_y, cor_rdata.max_y);
          e2    <= extent(pa_box.min_z, pa_box.max_z, cor_rdata.min_z, cor_rdata.max_z);
          state <= S_M0;
        end
        S_M0: begin
          acc   <= AREA_W'(prod);
          state <= S_M1;
        end
        S_M1: begin
          acc   <= acc + AREA_W'(prod);
          state <= S_M2;
        end
        S_M2: begin
          acc   <= acc + AREA_W'(prod);
          state <= S_CMP;
        end
        // first candidate wins ties
        S_CMP: begin
          if (acc < best_area) begin
            best_area <= acc;
            best_j    <= j[SLOT_W-1:0];
          end
          j     <= j + CNT_W'(1);
          state <= S_J0;
        end
        // nearest of a found
        S_RB: begin
          b     <= best_j;
          srch  <= best_j;
          ret   <= S_RC;
          state <= S_PA0;
        end
        // nearest of b found: merge when mutual
        S_RC: begin
          if (best_j == a) begin
            state <= S_MG0;
          end else begin
            a     <= b;
            b     <= best_j;
            srch  <= best_j;
            ret   <= S_RC;
            state <= S_PA0;
          end
        end
        S_MG0: state <= S_MG1;
        S_MG1: begin
          ia    <= act_rdata;
          state <= S_MG2;
        end
        S_MG2: begin
          ib    <= act_rdata;
          a_box <= cor_rdata;
          state <= S_MG3;
        end
        // create the node and emit it
        S_MG3: begin
          tail   <= (a == n_last) ? nn : act_rdata;
          node   <= '{node_index: nn, left_child: ia, right_child: ib,
                      out_min_x: un_box.min_x, out_min_y: un_box.min_y,
                      out_min_z: un_box.min_z, out_max_x: un_box.max_x,
                      out_max_y: un_box.max_y, out_max_z: un_box.max_z,
                      leaf_instance: '0, last_node: 1'b0};
          merged <= 1'b1;
          state  <= S_MG4;
        end
        // compact the list
        S_MG4: begin
          nn <= nn + NODE_W'(1);
          n  <= n - CNT_W'(1);
          if (a == n_last) begin
            a    <= b;
            srch <= b;
          end else begin
            srch <= a;
          end
          ret   <= S_RB;
          state <= (n > CNT_W'(2)) ? S_PA0 : S_RT0;
        end
        // root record
        S_RT0: state <= S_RT1;
        S_RT1: begin
          root  <= act_rdata;
          state <= S_RT2;
        end
        S_RT2: begin
          node   <= '{node_index: '0,
                      left_child: merged ? ia : '0,
                      right_child: merged ? ib : '0,
                      out_min_x: cor_rdata.min_x, out_min_y: cor_rdata.min_y,
                      out_min_z: cor_rdata.min_z, out_max_x: cor_rdata.max_x,
                      out_max_y: cor_rdata.max_y, out_max_z: cor_rdata.max_z,
                      leaf_instance: merged ? '0 : INST_W'(root - NODE_W'(1)),
                      last_node: 1'b1};
          count  <= '0;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the leaf count never passes capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_INSTANCES))
    else $error("leaf count above capacity");

  // results only come out of a build
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result outside a build");

  // the root record ends the build
  a_root_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && node.last_node) |-> !busy)
    else $error("still busy after root record");

  // active node count shrinks by one at each merge during a build
  a_n_shrink: assert property (@(posedge clk) disable iff (rst)
    (state == S_MG4) |=> (n == $past(n) - CNT_W'(1)))
    else $error("merge did not retire one node");

endmodule
